// File: rtl/pps_pkg.sv
// Shared widths, configuration layout and pipeline payload types for the point projector.
package pps_pkg;

    localparam int FIELD_W   = 32;
    localparam int PIX_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int T_W       = SUM_W + 1;
    localparam int DEN_W     = FIELD_W + FRAC_W;
    localparam int BOUND_W   = DEN_W + 1;
    localparam int NUM_W     = 64;
    localparam int DVS_W     = FIELD_W + 1;
    localparam int QUO_W     = FIELD_W + 1;
    localparam int REM_W     = DVS_W;
    localparam int SCR_W     = FIELD_W + 2;

    localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    localparam logic [FIELD_W-1:0] RST_X_SCALE  = 32'd65536;
    localparam logic [FIELD_W-1:0] RST_X_OFFSET = 32'd0;
    localparam logic [FIELD_W-1:0] RST_Y_SCALE  = 32'd65536;
    localparam logic [FIELD_W-1:0] RST_Y_OFFSET = 32'd0;
    localparam logic [PIX_W-1:0]   RST_VP_LEFT  = 16'd0;
    localparam logic [PIX_W-1:0]   RST_VP_TOP   = 16'd0;
    localparam logic [PIX_W-1:0]   RST_WIDTH    = 16'd640;
    localparam logic [PIX_W-1:0]   RST_HEIGHT   = 16'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SCALE  = 3'd0,
        REG_X_OFFSET = 3'd1,
        REG_Y_SCALE  = 3'd2,
        REG_Y_OFFSET = 3'd3,
        REG_VP_LEFT  = 3'd4,
        REG_VP_TOP   = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] proj_x_scale;
        logic [FIELD_W-1:0] proj_x_offset;
        logic [FIELD_W-1:0] proj_y_scale;
        logic [FIELD_W-1:0] proj_y_offset;
        logic [PIX_W-1:0]   viewport_left;
        logic [PIX_W-1:0]   viewport_top;
        logic [PIX_W-1:0]   size_x;
        logic [PIX_W-1:0]   size_y;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic [NUM_W-1:0]   num_x;
        logic [NUM_W-1:0]   num_y;
        logic [DVS_W-1:0]   dvs;
    } t_div_in;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
    } t_div_out;

endpackage

// File: rtl/pps_front.sv
// Front pipeline: projection products, numerators, clip test and screen-size scaling.
module pps_front
    import pps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [FIELD_W-1:0] i_view_x,
    input  logic [FIELD_W-1:0] i_view_y,
    input  logic [FIELD_W-1:0] i_view_z,
    input  t_cfg               i_cfg,
    output t_div_in            o_div
);

    logic                     r_s1_valid, r_s2_valid, r_s3_valid;
    logic                     r_s1_front, r_s2_front, r_s3_front;
    logic [FIELD_W-1:0]       r_s1_w, r_s2_w, r_s3_w;
    logic signed [PROD_W-1:0] r_s1_px, r_s1_qx, r_s1_py, r_s1_qy;
    logic signed [SUM_W-1:0]  r_s2_nx, r_s2_ny;
    logic signed [T_W-1:0]    r_s3_tx, r_s3_ty;
    t_div_in                  r_s4;

    logic signed [PROD_W-1:0] n_s1_px, n_s1_qx, n_s1_py, n_s1_qy;
    logic [FIELD_W-1:0]       n_s1_w;
    logic signed [SUM_W-1:0]  n_s2_nx, n_s2_ny;
    logic [DEN_W-1:0]         s3_den;
    logic signed [T_W-1:0]    n_s3_tx, n_s3_ty;
    logic [BOUND_W-1:0]       s4_bound;
    logic                     s4_in_x, s4_in_y;
    logic [BOUND_W+PIX_W-1:0] s4_prod_x, s4_prod_y;
    t_div_in                  n_s4;

    always_comb begin
        n_s1_px = $signed(i_view_x) * $signed(i_cfg.proj_x_scale);
        n_s1_qx = $signed(i_view_z) * $signed(i_cfg.proj_x_offset);
        n_s1_py = $signed(i_view_y) * $signed(i_cfg.proj_y_scale);
        n_s1_qy = $signed(i_view_z) * $signed(i_cfg.proj_y_offset);
        n_s1_w  = {FIELD_W{1'b0}} - i_view_z;
    end

    always_comb begin
        n_s2_nx = $signed({r_s1_px[PROD_W-1], r_s1_px}) + $signed({r_s1_qx[PROD_W-1], r_s1_qx});
        n_s2_ny = $signed({r_s1_py[PROD_W-1], r_s1_py}) + $signed({r_s1_qy[PROD_W-1], r_s1_qy});
    end

    always_comb begin
        s3_den  = {r_s2_w, {FRAC_W{1'b0}}};
        n_s3_tx = $signed({{(T_W-DEN_W){1'b0}}, s3_den}) + $signed({r_s2_nx[SUM_W-1], r_s2_nx});
        n_s3_ty = $signed({{(T_W-DEN_W){1'b0}}, s3_den}) - $signed({r_s2_ny[SUM_W-1], r_s2_ny});
    end

    // A point is inside the clip square when each shifted numerator lies in [0, 2 * depth * 2^FRAC_W].
    always_comb begin
        s4_bound  = {r_s3_w, {(FRAC_W+1){1'b0}}};
        s4_in_x   = !r_s3_tx[T_W-1]
                    && (r_s3_tx[T_W-2:0] <= {{(T_W-1-BOUND_W){1'b0}}, s4_bound});
        s4_in_y   = !r_s3_ty[T_W-1]
                    && (r_s3_ty[T_W-2:0] <= {{(T_W-1-BOUND_W){1'b0}}, s4_bound});
        s4_prod_x = r_s3_tx[BOUND_W-1:0] * i_cfg.size_x;
        s4_prod_y = r_s3_ty[BOUND_W-1:0] * i_cfg.size_y;
        n_s4.valid   = r_s3_valid;
        n_s4.visible = r_s3_front && s4_in_x && s4_in_y;
        n_s4.num_x   = s4_prod_x[NUM_W-1:0];
        n_s4.num_y   = s4_prod_y[NUM_W-1:0];
        n_s4.dvs     = {r_s3_w, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4.valid <= n_s4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_front   <= i_view_z[FIELD_W-1];
            r_s1_w       <= n_s1_w;
            r_s1_px      <= n_s1_px;
            r_s1_qx      <= n_s1_qx;
            r_s1_py      <= n_s1_py;
            r_s1_qy      <= n_s1_qy;
            r_s2_front   <= r_s1_front;
            r_s2_w       <= r_s1_w;
            r_s2_nx      <= n_s2_nx;
            r_s2_ny      <= n_s2_ny;
            r_s3_front   <= r_s2_front;
            r_s3_w       <= r_s2_w;
            r_s3_tx      <= n_s3_tx;
            r_s3_ty      <= n_s3_ty;
            r_s4.visible <= n_s4.visible;
            r_s4.num_x   <= n_s4.num_x;
            r_s4.num_y   <= n_s4.num_y;
            r_s4.dvs     <= n_s4.dvs;
        end
    end

    assign o_div = r_s4;

endmodule

// File: rtl/pps_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing one divisor.
module pps_div
    import pps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_in  i_div,
    output t_div_out o_div
);

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic [NUM_W-1:0]   num_x;
        logic [NUM_W-1:0]   num_y;
        logic [DVS_W-1:0]   dvs;
        logic [REM_W-1:0]   rem_x;
        logic [REM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
    } t_div_stage;

    function automatic logic [REM_W:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic             nbit,
        input logic [DVS_W-1:0] dvs
    );
        logic [REM_W:0] cand;
        logic [REM_W:0] diff;
        cand = {rem, nbit};
        diff = cand - {1'b0, dvs};
        if (cand >= {1'b0, dvs}) begin
            return {1'b1, diff[REM_W-1:0]};
        end else begin
            return {1'b0, cand[REM_W-1:0]};
        end
    endfunction

    t_div_stage w_cur   [QUO_W+1];
    t_div_stage r_stage [QUO_W];
    t_div_stage n_stage [QUO_W];

    always_comb begin
        w_cur[0].valid   = i_div.valid;
        w_cur[0].visible = i_div.visible;
        w_cur[0].num_x   = i_div.num_x;
        w_cur[0].num_y   = i_div.num_y;
        w_cur[0].dvs     = i_div.dvs;
        w_cur[0].rem_x   = {{(REM_W-(NUM_W-QUO_W)){1'b0}}, i_div.num_x[NUM_W-1:QUO_W]};
        w_cur[0].rem_y   = {{(REM_W-(NUM_W-QUO_W)){1'b0}}, i_div.num_y[NUM_W-1:QUO_W]};
        w_cur[0].quo_x   = {QUO_W{1'b0}};
        w_cur[0].quo_y   = {QUO_W{1'b0}};
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [REM_W:0] step_x;
        logic [REM_W:0] step_y;

        assign w_cur[k+1] = r_stage[k];

        always_comb begin
            step_x = div_step(w_cur[k].rem_x, w_cur[k].num_x[QUO_W-1-k], w_cur[k].dvs);
            step_y = div_step(w_cur[k].rem_y, w_cur[k].num_y[QUO_W-1-k], w_cur[k].dvs);
            n_stage[k]       = w_cur[k];
            n_stage[k].rem_x = step_x[REM_W-1:0];
            n_stage[k].rem_y = step_y[REM_W-1:0];
            n_stage[k].quo_x = {w_cur[k].quo_x[QUO_W-2:0], step_x[REM_W]};
            n_stage[k].quo_y = {w_cur[k].quo_y[QUO_W-2:0], step_y[REM_W]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[k].valid <= 1'b0;
            end else if (i_en) begin
                r_stage[k].valid <= n_stage[k].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[k].visible <= n_stage[k].visible;
                r_stage[k].num_x   <= n_stage[k].num_x;
                r_stage[k].num_y   <= n_stage[k].num_y;
                r_stage[k].dvs     <= n_stage[k].dvs;
                r_stage[k].rem_x   <= n_stage[k].rem_x;
                r_stage[k].rem_y   <= n_stage[k].rem_y;
                r_stage[k].quo_x   <= n_stage[k].quo_x;
                r_stage[k].quo_y   <= n_stage[k].quo_y;
            end
        end
    end

    always_comb begin
        o_div.valid   = w_cur[QUO_W].valid;
        o_div.visible = w_cur[QUO_W].visible;
        o_div.quo_x   = w_cur[QUO_W].quo_x;
        o_div.quo_y   = w_cur[QUO_W].quo_y;
    end

endmodule

// File: rtl/perspective_point_to_screen.sv
// Top level of the perspective point-to-screen projector with configuration registers.
// The block projects one view-space point per clock, while the output is not held, through a
// 38-stage pipeline: four stages of products, numerators and clip test, 33 stages of the divider
// that yields one quotient bit per stage, and one output register. A new transaction is taken
// every cycle unless the output is held; when the output is held, the whole pipeline holds with
// it and input ready drops.
module perspective_point_to_screen
    import pps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FIELD_W-1:0]   i_view_x,
    input  logic [FIELD_W-1:0]   i_view_y,
    input  logic [FIELD_W-1:0]   i_view_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_visible,
    output logic [FIELD_W-1:0]   o_screen_x,
    output logic [FIELD_W-1:0]   o_screen_y
);

    t_cfg               r_cfg;
    t_div_in            front_out;
    t_div_out           div_out;
    logic               pipe_en;
    logic               r_out_valid;
    logic               r_out_visible;
    logic [FIELD_W-1:0] r_out_x;
    logic [FIELD_W-1:0] r_out_y;
    logic [FIELD_W-1:0] n_out_x;
    logic [FIELD_W-1:0] n_out_y;
    logic signed [SCR_W-1:0] sum_x;
    logic signed [SCR_W-1:0] sum_y;

    function automatic logic [FIELD_W-1:0] sat_pix(input logic signed [SCR_W-1:0] v);
        if (v[SCR_W-1:FIELD_W-1] == {(SCR_W-FIELD_W+1){1'b0}}
            || v[SCR_W-1:FIELD_W-1] == {(SCR_W-FIELD_W+1){1'b1}}) begin
            return v[FIELD_W-1:0];
        end else if (v[SCR_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proj_x_scale  <= RST_X_SCALE;
            r_cfg.proj_x_offset <= RST_X_OFFSET;
            r_cfg.proj_y_scale  <= RST_Y_SCALE;
            r_cfg.proj_y_offset <= RST_Y_OFFSET;
            r_cfg.viewport_left <= RST_VP_LEFT;
            r_cfg.viewport_top  <= RST_VP_TOP;
            r_cfg.size_x        <= RST_WIDTH;
            r_cfg.size_y        <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_X_SCALE:  r_cfg.proj_x_scale  <= i_cfg_data;
                REG_X_OFFSET: r_cfg.proj_x_offset <= i_cfg_data;
                REG_Y_SCALE:  r_cfg.proj_y_scale  <= i_cfg_data;
                REG_Y_OFFSET: r_cfg.proj_y_offset <= i_cfg_data;
                REG_VP_LEFT:  r_cfg.viewport_left <= i_cfg_data[PIX_W-1:0];
                REG_VP_TOP:   r_cfg.viewport_top  <= i_cfg_data[PIX_W-1:0];
                REG_WIDTH:    r_cfg.size_x        <= i_cfg_data[PIX_W-1:0];
                REG_HEIGHT:   r_cfg.size_y        <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign pipe_en    = !r_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    pps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_in_valid),
        .i_view_x (i_view_x),
        .i_view_y (i_view_y),
        .i_view_z (i_view_z),
        .i_cfg    (r_cfg),
        .o_div    (front_out)
    );

    pps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_div   (front_out),
        .o_div   (div_out)
    );

    always_comb begin
        sum_x = $signed({{(SCR_W-FIELD_W){r_cfg.viewport_left[PIX_W-1]}},
                         r_cfg.viewport_left, {FRAC_W{1'b0}}})
                + $signed({{(SCR_W-QUO_W){1'b0}}, div_out.quo_x});
        sum_y = $signed({{(SCR_W-FIELD_W){r_cfg.viewport_top[PIX_W-1]}},
                         r_cfg.viewport_top, {FRAC_W{1'b0}}})
                + $signed({{(SCR_W-QUO_W){1'b0}}, div_out.quo_y});
        n_out_x = div_out.visible ? sat_pix(sum_x) : {FIELD_W{1'b0}};
        n_out_y = div_out.visible ? sat_pix(sum_y) : {FIELD_W{1'b0}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= div_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_visible <= div_out.visible;
            r_out_x       <= n_out_x;
            r_out_y       <= n_out_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_out_visible;
    assign o_screen_x  = r_out_x;
    assign o_screen_y  = r_out_y;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the perspective point-to-screen projector.
`timescale 1ns / 1ps

module tb_top;
    import pps_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_POINTS = 215;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic               visible;
        logic [FIELD_W-1:0] screen_x;
        logic [FIELD_W-1:0] screen_y;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    t_reg_idx           cfg_idx = REG_X_SCALE;
    logic [FIELD_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FIELD_W-1:0] view_x = '0;
    logic [FIELD_W-1:0] view_y = '0;
    logic [FIELD_W-1:0] view_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               visible;
    logic [FIELD_W-1:0] screen_x;
    logic [FIELD_W-1:0] screen_y;

    t_cfg        shadow_cfg;
    t_point      pending_points[$];
    t_pixel      expected_pixels[$];
    t_point      next_point;
    t_pixel      want;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_hold = 0;
    int unsigned recv_calm = 0;
    logic        long_hold_done = 1'b0;
    int          n_queued = 0;
    int          n_results = 0;
    int          n_visible = 0;
    int          n_mismatch = 0;
    int          n_settings = 1;
    int          idle_cycles = 0;

    perspective_point_to_screen dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_view_x    (view_x),
        .i_view_y    (view_y),
        .i_view_z    (view_z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_visible   (visible),
        .o_screen_x  (screen_x),
        .o_screen_y  (screen_y)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Maps an exact ndc numerator over den into Q16.16 pixels, floored and saturated.
    function automatic logic [FIELD_W-1:0] to_pixels(logic signed [65:0] num,
                                                     logic signed [65:0] den,
                                                     logic [PIX_W-1:0] origin,
                                                     logic [PIX_W-1:0] size);
        logic [95:0] span;
        logic [95:0] divisor;
        logic [95:0] offs;
        longint      pix;
        span = 96'(den + num);
        divisor = 96'(den);
        offs = span * size * 32768 / divisor;
        pix = longint'($signed(origin)) * 65536 + longint'(offs[63:0]);
        if (pix > longint'(SAT_MAX))
            return SAT_MAX;
        if (pix < longint'(SAT_MIN))
            return SAT_MIN;
        return pix[31:0];
    endfunction

    function automatic t_pixel project_point(t_point p, t_cfg c);
        t_pixel             r;
        logic signed [65:0] zs;
        logic signed [65:0] den;
        logic signed [65:0] num_x;
        logic signed [65:0] num_y;
        r = '0;
        zs = 66'($signed(p.z));
        if (zs >= 0)
            return r;
        den = -zs <<< 16;
        num_x = $signed(p.x) * $signed(c.proj_x_scale) + zs * $signed(c.proj_x_offset);
        num_y = -($signed(p.y) * $signed(c.proj_y_scale) + zs * $signed(c.proj_y_offset));
        if (num_x > den || num_x < -den || num_y > den || num_y < -den)
            return r;
        r.visible = 1'b1;
        r.screen_x = to_pixels(num_x, den, c.viewport_left, c.size_x);
        r.screen_y = to_pixels(num_y, den, c.viewport_top, c.size_y);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Picks an ndc numerator inside the clip square, or exactly on or just past its edge.
    function automatic logic signed [65:0] ndc_target(logic signed [65:0] den);
        logic signed [65:0] k;
        case ($urandom_range(0, 9))
            0: return den;
            1: return -den;
            2: return den + 1;
            3: return -den - 1;
            default: begin
                k = 66'($urandom_range(0, 65536));
                k = k - 32768;
                return den * k / 32768;
            end
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] solve_coord(logic signed [65:0] target,
                                                       logic signed [65:0] zs,
                                                       logic [FIELD_W-1:0] scale,
                                                       logic [FIELD_W-1:0] offset,
                                                       logic [FIELD_W-1:0] fallback);
        logic signed [65:0] ks;
        logic signed [65:0] q;
        ks = 66'($signed(scale));
        if (ks == 0)
            return fallback;
        q = (target - zs * $signed(offset)) / ks;
        if (q > 66'sd2147483647 || q < -66'sd2147483648)
            return fallback;
        return q[31:0];
    endfunction

    // Most points are aimed into the clip square; the rest are culled or pure noise.
    function automatic t_point make_point(t_cfg c);
        t_point             p;
        int unsigned        sel;
        logic signed [65:0] zs;
        logic signed [65:0] den;
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            p.z[31] = 1'b0;
            if (sel < 2)
                p.z = '0;
        end else if (sel >= 20) begin
            if ($urandom_range(0, 49) == 0)
                p.z = 32'h8000_0000;
            else
                p.z = -(($urandom >> $urandom_range(1, 31)) | 32'd1);
            zs = 66'($signed(p.z));
            den = -zs <<< 16;
            p.x = solve_coord(ndc_target(den), zs, c.proj_x_scale, c.proj_x_offset, p.x);
            p.y = solve_coord(-ndc_target(den), zs, c.proj_y_scale, c.proj_y_offset, p.y);
        end
        return p;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_scale();
        logic [FIELD_W-1:0] mag;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        mag = $urandom_range(4096, 1 << 20);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_offset();
        int off;
        off = $urandom_range(0, 1 << 18);
        return off - (1 << 17);
    endfunction

    function automatic logic [PIX_W-1:0] rand_size();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1, 4096));
    endfunction

    function automatic t_cfg phase_setting(int phase);
        t_cfg c;
        case (phase)
            1: c = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     16'h8000, 16'h7fff, 16'h0000, 16'hffff};
            2: c = '{32'h0001_0000, 32'h0000_0000, 32'hffff_0000, 32'h0000_8000,
                     16'h7fff, 16'h8000, 16'hffff, 16'hffff};
            3: c = '0;
            default: begin
                c.proj_x_scale = rand_scale();
                c.proj_x_offset = rand_offset();
                c.proj_y_scale = rand_scale();
                c.proj_y_offset = rand_offset();
                c.viewport_left = 16'($urandom);
                c.viewport_top = 16'($urandom);
                c.size_x = rand_size();
                c.size_y = rand_size();
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [FIELD_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic apply_config(t_cfg c);
        write_reg(REG_X_SCALE, c.proj_x_scale);
        write_reg(REG_X_OFFSET, c.proj_x_offset);
        write_reg(REG_Y_SCALE, c.proj_y_scale);
        write_reg(REG_Y_OFFSET, c.proj_y_offset);
        write_reg(REG_VP_LEFT, {16'($urandom), c.viewport_left});
        write_reg(REG_VP_TOP, {16'($urandom), c.viewport_top});
        write_reg(REG_WIDTH, {16'($urandom), c.size_x});
        write_reg(REG_HEIGHT, {16'($urandom), c.size_y});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        shadow_cfg = c;
        n_settings++;
    endtask

    task automatic push_point(t_point p);
        pending_points.push_back(p);
        n_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_points.size() != 0 || n_results != n_queued || in_valid);
    endtask

    initial begin
        shadow_cfg = '{RST_X_SCALE, RST_X_OFFSET, RST_Y_SCALE, RST_Y_OFFSET,
                       RST_VP_LEFT, RST_VP_TOP, RST_WIDTH, RST_HEIGHT};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_point('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        push_point('{32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff});
        push_point('{32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
        push_point('{32'h0000_0000, 32'h0000_0000, 32'hffff_ffff});
        push_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        push_point('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
        push_point('{32'h0001_0000, 32'h0001_0000, 32'hffff_0000});
        push_point('{32'h0001_0001, 32'h0000_0000, 32'hffff_0000});
        push_point('{32'h0000_0000, 32'hfffe_ffff, 32'hffff_0000});
        push_point('{32'hffff_0000, 32'hffff_0000, 32'hffff_0000});
        push_point('{32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff});
        push_point('{32'h8000_0000, 32'h0000_0000, 32'hffff_ffff});
        push_point('{32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff});
        push_point('{32'h0000_0000, 32'h8000_0000, 32'hffff_ffff});
        push_point('{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff});
        push_point('{32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff});
        push_point('{32'h0000_8000, 32'hffff_8000, 32'hffff_0000});
        push_point('{32'h8000_0000, 32'h0000_0000, 32'h0000_0000});
        push_point('{32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0000});
        push_point('{32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0001});
        wait_drained();

        for (int ph = 1; ph <= 6; ph++) begin
            apply_config(phase_setting(ph));
            @(negedge i_clk);
            repeat (PHASE_POINTS) push_point(make_point(shadow_cfg));
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0d projections never came out", expected_pixels.size());
            n_mismatch++;
        end
        $display("Projected %0d points under %0d register settings: %0d visible, %0d culled.",
                 n_results, n_settings, n_visible, n_results - n_visible);
        $display("Mismatches: %0d", n_mismatch);
        if (n_mismatch == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_points.size() != 0) begin
                next_point = pending_points.pop_front();
                in_valid <= 1'b1;
                view_x <= next_point.x;
                view_y <= next_point.y;
                view_z <= next_point.z;
                if (send_calm != 0) begin
                    send_calm <= send_calm - 1;
                end else begin
                    send_gap <= pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        send_calm <= $urandom_range(30, 100);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The one long hold lets the pipeline fill and push back on the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_hold <= 0;
        end else if (recv_hold != 0) begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else if (!long_hold_done && n_results >= 150) begin
            out_ready <= 1'b0;
            recv_hold <= 400;
            long_hold_done <= 1'b1;
        end else if (recv_calm != 0) begin
            out_ready <= 1'b1;
            recv_calm <= recv_calm - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            recv_hold <= pick_gap();
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 59) == 0)
                recv_calm <= $urandom_range(30, 120);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid === 1'b1 && out_ready) begin
                n_results <= n_results + 1;
                if (expected_pixels.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("Unexpected transaction: visible=%b x=%h y=%h",
                                 visible, screen_x, screen_y);
                    n_mismatch++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.visible) n_visible++;
                    if (visible !== want.visible || screen_x !== want.screen_x ||
                        screen_y !== want.screen_y) begin
                        if (n_mismatch < 10)
                            $display("Mismatch: expected visible=%b x=%h y=%h, got %b %h %h",
                                     want.visible, want.screen_x, want.screen_y,
                                     visible, screen_x, screen_y);
                        n_mismatch++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(project_point({view_x, view_y, view_z}, shadow_cfg));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
